@@ hdl/bfea_pkg.sv @@
// shared types, widths and codes for the best-fit extent allocator
`default_nettype none

package bfea_pkg;

    localparam int ADDR_W = 21;
    localparam int LEN_W  = 22;
    localparam int END_W  = LEN_W + 1;
    // size plus alignment bias, wide enough for any alignment up to 4096
    localparam int RND_W  = LEN_W + 1;

    localparam int DEF_SLOTS       = 128;
    localparam int DEF_ALIGN_BYTES = 64;

    localparam logic [LEN_W-1:0]  LEN_MAX    = {LEN_W{1'b1}};
    localparam logic [ADDR_W-1:0] RESET_BASE = 21'h005040;
    localparam logic [LEN_W-1:0]  RESET_POOL = 22'd2076608;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = LEN_W;

    typedef enum logic [1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_INIT  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOFIT = 2'd1,
        ST_ZERO  = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_ADDR = 1'b0,
        CFG_POOL_SIZE = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROUND,
        S_SCAN,
        S_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  req_size;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] alloc_address;
        logic [1:0]        status;
        logic [LEN_W-1:0]  free_total;
        logic [LEN_W-1:0]  largest_free;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic round_done;
        logic scan_done;
    } dp_sts_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [LEN_W-1:0]  len;
    } extent_t;

endpackage

`default_nettype wire

@@ hdl/bfea_round.sv @@
// round-up of a size to the alignment by reciprocal multiplication
`default_nettype none

module bfea_round
    import bfea_pkg::*;
#(
    parameter int ALIGN_BYTES = DEF_ALIGN_BYTES
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [LEN_W-1:0] raw,
    output logic             done,
    output logic [LEN_W-1:0] size
);

    localparam int AW = $clog2(ALIGN_BYTES) + 1;
    localparam int RW = AW + 1;
    localparam int MW = RND_W + 1;
    localparam int PW = RND_W + MW;
    localparam int BW = MW + AW;
    localparam logic [AW-1:0]    ALIGN_A = AW'(ALIGN_BYTES);
    localparam logic [RW-1:0]    ALIGN_R = RW'(ALIGN_BYTES);
    localparam logic [MW-1:0]    RECIP   = MW'((1 << RND_W) / ALIGN_BYTES);
    localparam logic [RND_W-1:0] BIAS    = RND_W'(ALIGN_BYTES - 1);

    logic [RND_W-1:0] num_reg;
    logic [PW-1:0]    prod_reg;
    logic [RW-1:0]    rem_reg;
    logic [RW-1:0]    fix_reg;
    logic [2:0]       step_reg;
    logic             done_reg;
    logic [MW-1:0]    quot;
    logic [BW-1:0]    back;
    logic [RND_W-1:0] rem_wide;
    logic [RND_W-1:0] diff;

    // estimated quotient is exact or one short, so the remainder is below twice the alignment
    always_comb
    begin
        quot     = prod_reg[PW-1:RND_W];
        back     = BW'(quot) * BW'(ALIGN_A);
        rem_wide = num_reg - back[RND_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= {step_reg[1:0], go};
            done_reg <= step_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            num_reg <= RND_W'(raw) + BIAS;
        end
        if (step_reg[0])
        begin
            prod_reg <= PW'(num_reg) * PW'(RECIP);
        end
        if (step_reg[1])
        begin
            rem_reg <= rem_wide[RW-1:0];
        end
        if (step_reg[2])
        begin
            fix_reg <= (rem_reg >= ALIGN_R) ? (rem_reg - ALIGN_R) : rem_reg;
        end
    end

    // rounded size saturates at the largest length
    assign diff = num_reg - RND_W'(fix_reg);
    assign size = diff[RND_W-1] ? LEN_MAX : diff[LEN_W-1:0];
    assign done = done_reg;

endmodule

`default_nettype wire

@@ hdl/bfea_datapath.sv @@
// extent table, scan accumulators, write-back and result registers
`default_nettype none

module bfea_datapath
    import bfea_pkg::*;
#(
    parameter int SLOTS       = DEF_SLOTS,
    parameter int ALIGN_BYTES = DEF_ALIGN_BYTES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctrl_cmd_t             cmd,
    output dp_sts_t               sts,
    input  req_t                  req,
    output rsp_t                  rsp,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IW    = $clog2(SLOTS);
    localparam int ACC_W = LEN_W + IW;
    localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_ALLOC,
        MODE_FREE
    } mode_t;

    logic [ADDR_W-1:0] base_reg;
    logic [LEN_W-1:0]  pool_reg;

    extent_t           mem [SLOTS];
    extent_t           rd_reg;
    logic              mem_we;
    logic [IW-1:0]     mem_wa;
    extent_t           mem_wd;

    logic [SLOTS-1:0]  valid_reg, valid_next;
    logic              fresh_reg, fresh_next;

    mode_t             mode_reg, mode_next;
    status_t           pre_status_reg, pre_status_next;
    logic [ADDR_W-1:0] loc_reg, loc_next;
    logic [LEN_W-1:0]  size_reg, size_next;

    logic              rnd_go;
    logic [LEN_W-1:0]  rnd_raw;
    logic [LEN_W-1:0]  rnd_size;
    logic              rnd_done;

    logic [IW-1:0]     rd_idx_reg;
    logic              rd_active_reg;
    logic              proc_valid_reg;
    logic [IW-1:0]     proc_idx_reg;

    logic [ACC_W-1:0]  sum_reg, sum_next;
    logic [LEN_W-1:0]  max1_reg, max1_next;
    logic [IW-1:0]     max1_idx_reg, max1_idx_next;
    logic [LEN_W-1:0]  max2_reg, max2_next;
    logic              best_found_reg, best_found_next;
    logic [IW-1:0]     best_idx_reg, best_idx_next;
    logic [ADDR_W-1:0] best_start_reg, best_start_next;
    logic [LEN_W-1:0]  best_len_reg, best_len_next;
    logic              tgt_found_reg, tgt_found_next;
    logic [IW-1:0]     tgt_idx_reg, tgt_idx_next;

    rsp_t              rsp_reg, rsp_next;

    extent_t           slot;
    logic              slot_valid;
    logic [END_W-1:0]  loc_end;
    logic [END_W-1:0]  slot_end;
    logic              hit_below;
    logic              hit_above;
    logic              merge;
    logic              keep;
    logic              better;
    logic [END_W-1:0]  merge_sum;
    logic [LEN_W-1:0]  merge_size;
    logic [LEN_W-1:0]  alloc_len;
    logic [ADDR_W-1:0] alloc_start;
    logic [ACC_W-1:0]  total_wide;
    logic [LEN_W-1:0]  largest;

    bfea_round #(
        .ALIGN_BYTES (ALIGN_BYTES)
    ) u_round (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (rnd_go),
        .raw   (rnd_raw),
        .done  (rnd_done),
        .size  (rnd_size)
    );

    // config write beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= RESET_BASE;
            pool_reg <= RESET_POOL;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_BASE_ADDR: base_reg <= cfg_data[ADDR_W-1:0];
                CFG_POOL_SIZE: pool_reg <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_reg <= mem[rd_idx_reg];
    end

    // slot 0 holds the reset extent until first written or until an init request
    always_comb
    begin
        if (proc_idx_reg == '0 && fresh_reg)
        begin
            slot.start = RESET_BASE;
            slot.len   = RESET_POOL;
        end
        else
        begin
            slot = rd_reg;
        end
        slot_valid = valid_reg[proc_idx_reg];
    end

    always_comb
    begin
        loc_end    = END_W'(loc_reg) + END_W'(size_reg);
        slot_end   = END_W'(slot.start) + END_W'(slot.len);
        hit_below  = (slot_end == END_W'(loc_reg));
        hit_above  = (END_W'(slot.start) == loc_end);
        merge      = proc_valid_reg && slot_valid && (mode_reg == MODE_FREE)
                     && (hit_below || hit_above);
        keep       = proc_valid_reg && slot_valid && !merge;
        merge_sum  = END_W'(size_reg) + END_W'(slot.len);
        merge_size = merge_sum[END_W-1] ? LEN_MAX : merge_sum[LEN_W-1:0];
        better     = proc_valid_reg && slot_valid && (mode_reg == MODE_ALLOC)
                     && (slot.len >= size_reg)
                     && (!best_found_reg || slot.len < best_len_reg);
        alloc_len   = best_len_reg - size_reg;
        alloc_start = best_start_reg + size_reg[ADDR_W-1:0];
    end

    always_comb
    begin
        mode_next       = mode_reg;
        pre_status_next = pre_status_reg;
        loc_next        = loc_reg;
        size_next       = size_reg;
        valid_next      = valid_reg;
        fresh_next      = fresh_reg;
        sum_next        = sum_reg;
        max1_next       = max1_reg;
        max1_idx_next   = max1_idx_reg;
        max2_next       = max2_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_start_next = best_start_reg;
        best_len_next   = best_len_reg;
        tgt_found_next  = tgt_found_reg;
        tgt_idx_next    = tgt_idx_reg;
        rsp_next        = rsp_reg;
        mem_we          = 1'b0;
        mem_wa          = best_idx_reg;
        mem_wd          = '{start: loc_reg, len: size_reg};
        rnd_go          = cmd.load;
        rnd_raw         = req.req_size;
        total_wide      = sum_reg;
        largest         = max1_reg;

        if (cmd.load)
        begin
            loc_next        = req.address;
            pre_status_next = ST_OK;
            mode_next       = MODE_NONE;
            case (req.kind)
                KIND_ALLOC:
                begin
                    if (req.req_size == '0)
                        pre_status_next = ST_ZERO;
                    else
                        mode_next = MODE_ALLOC;
                end
                KIND_FREE:
                begin
                    if (req.req_size == '0)
                        pre_status_next = ST_ZERO;
                    else
                        mode_next = MODE_FREE;
                end
                KIND_INIT:
                begin
                    rnd_raw    = pool_reg;
                    loc_next   = base_reg;
                    valid_next = '0;
                    fresh_next = 1'b0;
                    if (pool_reg == '0)
                        pre_status_next = ST_ZERO;
                    else
                        mode_next = MODE_FREE;
                end
                default: ;
            endcase
        end

        if (cmd.scan_start)
        begin
            size_next       = rnd_size;
            sum_next        = '0;
            max1_next       = '0;
            max1_idx_next   = '0;
            max2_next       = '0;
            best_found_next = 1'b0;
            tgt_found_next  = 1'b0;
        end

        if (proc_valid_reg)
        begin
            if (merge)
            begin
                valid_next[proc_idx_reg] = 1'b0;
                size_next = merge_size;
                if (hit_below)
                    loc_next = slot.start;
            end
            if (keep)
            begin
                sum_next = sum_reg + ACC_W'(slot.len);
                if (slot.len > max1_reg)
                begin
                    max2_next     = max1_reg;
                    max1_next     = slot.len;
                    max1_idx_next = proc_idx_reg;
                end
                else if (slot.len > max2_reg)
                begin
                    max2_next = slot.len;
                end
            end
            if (better)
            begin
                best_found_next = 1'b1;
                best_idx_next   = proc_idx_reg;
                best_start_next = slot.start;
                best_len_next   = slot.len;
            end
            if (!tgt_found_reg && (!slot_valid || merge))
            begin
                tgt_found_next = 1'b1;
                tgt_idx_next   = proc_idx_reg;
            end
        end

        if (cmd.finish)
        begin
            rsp_next.alloc_address = '0;
            case (mode_reg)
                MODE_ALLOC:
                begin
                    if (best_found_reg)
                    begin
                        rsp_next.status        = ST_OK;
                        rsp_next.alloc_address = best_start_reg;
                        total_wide = sum_reg - ACC_W'(size_reg);
                        if (best_idx_reg == max1_idx_reg)
                            largest = (alloc_len > max2_reg) ? alloc_len : max2_reg;
                        if (alloc_len == '0)
                        begin
                            valid_next[best_idx_reg] = 1'b0;
                        end
                        else
                        begin
                            mem_we = 1'b1;
                            mem_wa = best_idx_reg;
                            mem_wd = '{start: alloc_start, len: alloc_len};
                        end
                    end
                    else
                    begin
                        rsp_next.status = ST_NOFIT;
                    end
                end
                MODE_FREE:
                begin
                    if (tgt_found_reg)
                    begin
                        rsp_next.status = ST_OK;
                        total_wide = sum_reg + ACC_W'(size_reg);
                        largest    = (size_reg > max1_reg) ? size_reg : max1_reg;
                        mem_we     = 1'b1;
                        mem_wa     = tgt_idx_reg;
                        mem_wd     = '{start: loc_reg, len: size_reg};
                        valid_next[tgt_idx_reg] = 1'b1;
                    end
                    else
                    begin
                        rsp_next.status = ST_FULL;
                    end
                end
                default:
                begin
                    rsp_next.status = pre_status_reg;
                end
            endcase
            if (mem_we && mem_wa == '0)
                fresh_next = 1'b0;
            rsp_next.free_total   = (total_wide > ACC_W'(LEN_MAX)) ? LEN_MAX
                                                                   : total_wide[LEN_W-1:0];
            rsp_next.largest_free = largest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= SLOTS'(1);
            fresh_reg      <= 1'b1;
            mode_reg       <= MODE_NONE;
            pre_status_reg <= ST_OK;
            best_found_reg <= 1'b0;
            tgt_found_reg  <= 1'b0;
            rd_active_reg  <= 1'b0;
            rd_idx_reg     <= '0;
            proc_valid_reg <= 1'b0;
            proc_idx_reg   <= '0;
        end
        else
        begin
            valid_reg      <= valid_next;
            fresh_reg      <= fresh_next;
            mode_reg       <= mode_next;
            pre_status_reg <= pre_status_next;
            best_found_reg <= best_found_next;
            tgt_found_reg  <= tgt_found_next;
            proc_valid_reg <= rd_active_reg;
            proc_idx_reg   <= rd_idx_reg;
            if (cmd.scan_start)
            begin
                rd_active_reg <= 1'b1;
                rd_idx_reg    <= '0;
            end
            else if (rd_active_reg)
            begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
                if (rd_idx_reg == LAST_SLOT)
                    rd_active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        loc_reg        <= loc_next;
        size_reg       <= size_next;
        sum_reg        <= sum_next;
        max1_reg       <= max1_next;
        max1_idx_reg   <= max1_idx_next;
        max2_reg       <= max2_next;
        best_idx_reg   <= best_idx_next;
        best_start_reg <= best_start_next;
        best_len_reg   <= best_len_next;
        tgt_idx_reg    <= tgt_idx_next;
        rsp_reg        <= rsp_next;
    end

    assign sts.round_done = rnd_done;
    assign sts.scan_done  = proc_valid_reg && (proc_idx_reg == LAST_SLOT);
    assign rsp            = rsp_reg;

endmodule

`default_nettype wire

@@ hdl/bfea_ctrl.sv @@
// request sequencer: round, table scan, write-back and result strobe
`default_nettype none

module bfea_ctrl
    import bfea_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    output logic      done,
    output ctrl_cmd_t cmd,
    input  dp_sts_t   sts
);

    ctrl_state_t state_reg, state_next;
    logic        done_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                    state_next = S_ROUND;
            end
            S_ROUND:
            begin
                if (sts.round_done)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy = 1'b1;
        cmd  = '0;
        case (state_reg)
            S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            S_ROUND:
            begin
                cmd.scan_start = sts.round_done;
            end
            S_SCAN: ;
            S_FINISH:
            begin
                cmd.finish = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.finish;
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

@@ hdl/best_fit_extent_allocator_unit.sv @@
// top level of the best-fit extent allocator
// the done strobe comes with the write-back, after the rounding and one pass over the table
// requests do not overlap: each takes the rounding unit and one pass over the extent table
//   through its single read port
// a new request is taken in the cycle the result is shown; results cannot be stalled
// reset: base and pool config and one table extent take the reset base and pool size
`default_nettype none

module best_fit_extent_allocator_unit
    import bfea_pkg::*;
#(
    parameter int SLOTS       = DEF_SLOTS,
    parameter int ALIGN_BYTES = DEF_ALIGN_BYTES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  req_t                  req,
    output logic                  done,
    output rsp_t                  rsp,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ctrl_cmd_t cmd;
    dp_sts_t   sts;

    bfea_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .sts   (sts)
    );

    bfea_datapath #(
        .SLOTS       (SLOTS),
        .ALIGN_BYTES (ALIGN_BYTES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req       (req),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

@@ hdl/bfea_checker.sv @@
// port-level checks for the allocator, bound to the top level
`default_nettype none

module bfea_checker
    import bfea_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input rsp_t rsp
);

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request beat not followed by busy");

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) && !busy))
        else $error("result strobe without a finished request");

    a_largest_in_total: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.largest_free <= rsp.free_total))
        else $error("largest extent exceeds free total");

    a_error_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status != ST_OK) |-> (rsp.alloc_address == '0))
        else $error("address reported on a failed request");

endmodule

bind best_fit_extent_allocator_unit bfea_checker u_bfea_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

`default_nettype wire
